// File: hw/rtl/nlp_pkg.sv
// ----------------------------------------------------------------------------
// NACK list packer package
// Beat types, queue entry type and constants shared by the packer modules.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam logic [9:0]  RESET_MAX_ITEMS = 10'd347;
    localparam logic [12:0] HEADER_BYTES    = 13'd8;
    localparam int          MASK_SEL_BITS   = 4;

    typedef struct packed {
        logic [15:0] seq_number;
        logic        list_end;
    } t_nlp_in_beat;

    typedef struct packed {
        logic [15:0] base_id;
        logic [15:0] follow_mask;
        logic        final_item;
        logic [12:0] packet_length;
    } t_nlp_out_beat;

    // Each queue entry gives one or two output beats.
    typedef struct packed {
        logic          two;
        t_nlp_out_beat r0;
        t_nlp_out_beat r1;
    } t_nlp_entry;

    function automatic logic [12:0] nlp_length(input logic [10:0] items);
        nlp_length = HEADER_BYTES + {items, 2'b00};
    endfunction

endpackage

// File: hw/rtl/nlp_front.sv
// ----------------------------------------------------------------------------
// NACK list packer front end
// Classifies each sequence number against the open item and builds the
// output beats that it causes.
// ----------------------------------------------------------------------------
module nlp_front import nlp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_nlp_in_beat i_data,
    input  logic         i_cfg_wr_en,
    input  logic [9:0]   i_cfg_wr_data,
    output logic         o_push,
    output t_nlp_entry   o_entry
);

    logic [9:0]  r_max_items;
    logic [15:0] r_open_base, n_open_base;
    logic [15:0] r_open_mask, n_open_mask;
    logic        r_item_open, n_item_open;
    logic [9:0]  r_items_done, n_items_done;
    logic        r_cap_reached, n_cap_reached;

    logic [9:0]  cap;
    logic [9:0]  done_inc;
    logic [15:0] shift;
    logic        in_mask;
    logic [15:0] mask_or;

    assign cap      = (r_max_items == 10'd0) ? 10'd1 : r_max_items;
    assign done_inc = r_items_done + 10'd1;
    assign shift    = i_data.seq_number - r_open_base - 16'd1;
    assign in_mask  = (shift[15:MASK_SEL_BITS] == '0);
    assign mask_or  = r_open_mask | (16'd1 << shift[MASK_SEL_BITS-1:0]);

    always_comb begin
        n_open_base   = r_open_base;
        n_open_mask   = r_open_mask;
        n_item_open   = r_item_open;
        n_items_done  = r_items_done;
        n_cap_reached = r_cap_reached;
        o_push        = 1'b0;
        o_entry       = '0;
        if (i_accept) begin
            priority if (r_cap_reached) begin
                if (i_data.list_end) begin
                    n_open_base   = '0;
                    n_open_mask   = '0;
                    n_item_open   = 1'b0;
                    n_items_done  = '0;
                    n_cap_reached = 1'b0;
                end
            end else if (!r_item_open || in_mask) begin
                if (!r_item_open) begin
                    n_open_base = i_data.seq_number;
                    n_open_mask = '0;
                    n_item_open = 1'b1;
                end else begin
                    n_open_mask = mask_or;
                end
                if (i_data.list_end) begin
                    o_push                   = 1'b1;
                    o_entry.r0.base_id       = n_open_base;
                    o_entry.r0.follow_mask   = n_open_mask;
                    o_entry.r0.final_item    = 1'b1;
                    o_entry.r0.packet_length = nlp_length({1'b0, done_inc});
                    n_open_base   = '0;
                    n_open_mask   = '0;
                    n_item_open   = 1'b0;
                    n_items_done  = '0;
                    n_cap_reached = 1'b0;
                end
            end else begin
                o_push                 = 1'b1;
                o_entry.r0.base_id     = r_open_base;
                o_entry.r0.follow_mask = r_open_mask;
                n_items_done           = done_inc;
                if (done_inc >= cap) begin
                    o_entry.r0.final_item    = 1'b1;
                    o_entry.r0.packet_length = nlp_length({1'b0, done_inc});
                    n_cap_reached = 1'b1;
                    n_item_open   = 1'b0;
                end else begin
                    n_open_base = i_data.seq_number;
                    n_open_mask = '0;
                    if (i_data.list_end) begin
                        o_entry.two              = 1'b1;
                        o_entry.r1.base_id       = i_data.seq_number;
                        o_entry.r1.follow_mask   = '0;
                        o_entry.r1.final_item    = 1'b1;
                        o_entry.r1.packet_length =
                            nlp_length({1'b0, done_inc} + 11'd1);
                    end
                end
                if (i_data.list_end) begin
                    n_open_base   = '0;
                    n_open_mask   = '0;
                    n_item_open   = 1'b0;
                    n_items_done  = '0;
                    n_cap_reached = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_items   <= RESET_MAX_ITEMS;
            r_open_base   <= '0;
            r_open_mask   <= '0;
            r_item_open   <= 1'b0;
            r_items_done  <= '0;
            r_cap_reached <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_items <= i_cfg_wr_data;
            end
            r_open_base   <= n_open_base;
            r_open_mask   <= n_open_mask;
            r_item_open   <= n_item_open;
            r_items_done  <= n_items_done;
            r_cap_reached <= n_cap_reached;
        end
    end

endmodule

// File: hw/rtl/nlp_queue.sv
// ----------------------------------------------------------------------------
// NACK list packer queue
// Short register queue of packed entries between the front and back ends.
// ----------------------------------------------------------------------------
module nlp_queue import nlp_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_nlp_entry i_entry,
    input  logic       i_pop,
    output t_nlp_entry o_head,
    output logic       o_nonempty,
    output logic       o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_nlp_entry    r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// File: hw/rtl/nlp_back.sv
// ----------------------------------------------------------------------------
// NACK list packer back end
// Unpacks queue entries into output beats through an output register.
// ----------------------------------------------------------------------------
module nlp_back import nlp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_nlp_entry    i_head,
    input  logic          i_nonempty,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_nlp_out_beat o_out_data
);

    logic          r_valid, n_valid;
    logic          r_half, n_half;
    t_nlp_out_beat r_data, n_data;
    logic          load;

    assign load = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        n_half  = r_half;
        n_data  = r_data;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = i_nonempty;
            if (i_nonempty) begin
                n_data = r_half ? i_head.r1 : i_head.r0;
                if (i_head.two && !r_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half = 1'b0;
                    o_pop  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_half  <= n_half;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// File: hw/rtl/nack_list_packer.sv
// ----------------------------------------------------------------------------
// NACK list packer
// Packs a list of lost sequence numbers into generic NACK items.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake              Beat
//  in       in   i_in_valid/o_in_stall  seq_number, list_end
//  out      out  o_out_valid/i_out_stall base_id, follow_mask, final_item,
//                                        packet_length
//  cfg      in   i_cfg_wr_en            max_items
//
// One sequence number is taken every cycle while the entry queue has room.
// A list end outside the open item gives two output beats unless the cap is
// reached, and both pass the output register; the queue depth sets how long
// such bursts and output stalls are absorbed before o_in_stall rises.
// Reset is synchronous; a beat can be taken in the first cycle with i_rst_n high.
// ----------------------------------------------------------------------------
module nack_list_packer import nlp_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  t_nlp_in_beat  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output t_nlp_out_beat o_out_data,
    input  logic          i_cfg_wr_en,
    input  logic [9:0]    i_cfg_wr_data
);

    logic       accept;
    logic       push;
    logic       pop;
    logic       nonempty;
    logic       full;
    t_nlp_entry push_entry;
    t_nlp_entry head;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    nlp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data        (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    nlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_head     (head),
        .o_nonempty (nonempty),
        .o_full     (full)
    );

    nlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_nonempty  (nonempty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/nlp_checker.sv
// ----------------------------------------------------------------------------
// NACK list packer checker
// Port-level assertions on the packer, bound to the top level.
// ----------------------------------------------------------------------------
module nlp_checker import nlp_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input t_nlp_out_beat o_out_data
);

    a_reset_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output beat valid straight after reset.");

    a_reset_in_open: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("Input stalled straight after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled output beat changed.");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.final_item |-> o_out_data.packet_length == 13'd0)
        else $error("Non-final beat carries a packet length.");

    a_len_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.final_item |->
            o_out_data.packet_length >= 13'd12 && o_out_data.packet_length[1:0] == 2'b00)
        else $error("Final beat carries a malformed packet length.");

endmodule

bind nack_list_packer nlp_checker u_nlp_checker (.*);
